[rtl/core/assert_macros.svh]
// Assertion macros shared by the circumcenter core modules.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CC3_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cc3 assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define CC3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cc3 assertion failed");

`endif

[rtl/core/cc3_pkg.sv]
// Types and constants of the 3-D circumcenter core.
// No dependencies; used by cc3_front, cc3_back and circumcenter_3d_unit.
package cc3_pkg;

    localparam int COORD_W = 32;
    // Edge vectors, dot products, Gram products, numerators.
    localparam int VW = COORD_W + 1;
    localparam int XW = 2 * COORD_W + 4;
    localparam int YW = 2 * XW;
    localparam int ZW = YW + VW;
    // Divider: numerator 2*|num|, denominator 2*det, quotient bits.
    localparam int NW = ZW + 2;
    localparam int DW = YW;
    localparam int QB = COORD_W + 2;
    // Center before clamping.
    localparam int RW = COORD_W + 3;

    localparam logic signed [RW-1:0] RES_MAX = {4'b0000, {(COORD_W-1){1'b1}}};
    localparam logic signed [RW-1:0] RES_MIN = {4'b1111, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DEGEN = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [1:0]                status;
    } out_word_t;

    // Queue entry: first point and both edge vectors.
    typedef struct packed {
        logic [2:0][COORD_W-1:0] p1;
        logic [2:0][VW-1:0]      v1;
        logic [2:0][VW-1:0]      v2;
    } edge_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p1;
        logic [DW-1:0]           den;
        logic                    degen;
    } den_side_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] p1;
        logic [2:0]              neg;
        logic                    degen;
    } div_side_t;

    // Queue handshake toward the back end.
    typedef struct packed {
        logic valid;
        logic pop;
    } q_ctrl_t;

endpackage

[rtl/core/cc3_mul.sv]
// Pipelined multi-lane signed multiplier, digit by digit of the second operand.
// Standalone; carries a sideband word alongside the products.
module cc3_mul #(
    parameter int AW    = 33,
    parameter int BW    = 33,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [AW-1:0]    a [LANES],
    input  logic signed [BW-1:0]    b [LANES],
    input  logic [SW-1:0]           side_in,
    output logic                    out_valid,
    output logic signed [AW+BW-1:0] p [LANES],
    output logic [SW-1:0]           side_out
);

    localparam int DIG  = (AW <= 32) ? 32 : ((AW >= 1024) ? 1 : 1024 / AW);
    localparam int NST  = (BW + DIG - 1) / DIG;
    localparam int BPAD = NST * DIG;
    localparam int PW   = AW + BW;

    logic [NST+1:0]    vld_reg;
    logic [LANES-1:0]  neg_reg [NST+1];
    logic [AW-1:0]     am_reg  [NST+1][LANES];
    logic [BPAD-1:0]   bm_reg  [NST+1][LANES];
    logic [PW-1:0]     acc_reg [NST+1][LANES];
    logic [SW-1:0]     sd_reg  [NST+2];
    logic signed [PW-1:0] p_reg [LANES];

    logic [AW-1:0] amag [LANES];
    logic [BW-1:0] bmag [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            amag[l] = a[l][AW-1] ? $unsigned(-a[l]) : $unsigned(a[l]);
            bmag[l] = b[l][BW-1] ? $unsigned(-b[l]) : $unsigned(b[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST:0], in_valid};
    end

    // Take magnitudes and the product sign.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                am_reg[0][l]  <= amag[l];
                bm_reg[0][l]  <= BPAD'(bmag[l]);
                acc_reg[0][l] <= '0;
                neg_reg[0][l] <= a[l][AW-1] ^ b[l][BW-1];
            end
            sd_reg[0] <= side_in;
        end
    end

    // Add one partial product per stage.
    for (genvar k = 1; k <= NST; k++)
    begin : g_stage
        logic [AW+DIG-1:0] pp [LANES];

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
                pp[l] = (AW+DIG)'(am_reg[k-1][l])
                      * (AW+DIG)'(bm_reg[k-1][l][(k-1)*DIG +: DIG]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    acc_reg[k][l] <= acc_reg[k-1][l] + (PW'(pp[l]) << ((k-1)*DIG));
                    am_reg[k][l]  <= am_reg[k-1][l];
                    bm_reg[k][l]  <= bm_reg[k-1][l];
                end
                neg_reg[k] <= neg_reg[k-1];
                sd_reg[k]  <= sd_reg[k-1];
            end
        end
    end

    // Restore the sign.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
                p_reg[l] <= neg_reg[NST][l] ? -$signed(acc_reg[NST][l])
                                            : $signed(acc_reg[NST][l]);
            sd_reg[NST+1] <= sd_reg[NST];
        end
    end

    assign out_valid = vld_reg[NST+1];
    assign p         = p_reg;
    assign side_out  = sd_reg[NST+1];

endmodule

[rtl/core/cc3_div.sv]
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// Standalone; flags quotients that do not fit QB bits.
module cc3_div #(
    parameter int NW    = 171,
    parameter int DW    = 136,
    parameter int QB    = 34,
    parameter int LANES = 3,
    parameter int SW    = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   n [LANES],
    input  logic [DW-1:0]   d,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [QB-1:0]   f [LANES],
    output logic [LANES-1:0] ovf,
    output logic [SW-1:0]   side_out
);

    localparam int HW = NW - QB;

    logic [QB:0]      vld_reg;
    logic [DW-1:0]    r_reg  [QB+1][LANES];
    logic [QB-1:0]    nf_reg [QB+1][LANES];
    logic [DW-1:0]    d_reg  [QB+1];
    logic [LANES-1:0] ov_reg [QB+1];
    logic [SW-1:0]    sd_reg [QB+1];

    logic [HW-1:0]    hi [LANES];
    logic [LANES-1:0] ov_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            hi[l]      = n[l][NW-1:QB];
            ov_next[l] = (HW+DW)'(hi[l]) >= (HW+DW)'(d);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[QB-1:0], in_valid};
    end

    // Seed the remainder with the high numerator bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                r_reg[0][l]  <= DW'(hi[l]);
                nf_reg[0][l] <= n[l][QB-1:0];
            end
            d_reg[0]  <= d;
            ov_reg[0] <= ov_next;
            sd_reg[0] <= side_in;
        end
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_step
        logic [DW:0] r2 [LANES];
        logic [LANES-1:0] ge;

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                r2[l] = {r_reg[i-1][l], nf_reg[i-1][l][QB-1]};
                ge[l] = r2[l] >= {1'b0, d_reg[i-1]};
            end
        end

        // Shift in one quotient bit, subtract when it is set.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    r_reg[i][l]  <= ge[l] ? DW'(r2[l] - {1'b0, d_reg[i-1]}) : r2[l][DW-1:0];
                    nf_reg[i][l] <= {nf_reg[i-1][l][QB-2:0], ge[l]};
                end
                d_reg[i]  <= d_reg[i-1];
                ov_reg[i] <= ov_reg[i-1];
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign f         = nf_reg[QB];
    assign ovf       = ov_reg[QB];
    assign side_out  = sd_reg[QB];

endmodule

[rtl/core/cc3_front.sv]
// Front end: accepts point triples, forms edge vectors, queues them.
// Depends on cc3_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cc3_front
    import cc3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_data,
    output q_ctrl_t  q_ctrl,
    input  logic     q_pop,
    output edge_t    q_data
);

    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, rd_ptr_reg;
    edge_t      mem_reg [2];
    edge_t      push_word;
    logic       push, pop;

    always_comb
    begin
        push_word.p1[0] = in_data.first_x;
        push_word.p1[1] = in_data.first_y;
        push_word.p1[2] = in_data.first_z;
        push_word.v1[0] = VW'(in_data.second_x) - VW'(in_data.first_x);
        push_word.v1[1] = VW'(in_data.second_y) - VW'(in_data.first_y);
        push_word.v1[2] = VW'(in_data.second_z) - VW'(in_data.first_z);
        push_word.v2[0] = VW'(in_data.third_x) - VW'(in_data.first_x);
        push_word.v2[1] = VW'(in_data.third_y) - VW'(in_data.first_y);
        push_word.v2[2] = VW'(in_data.third_z) - VW'(in_data.first_z);
    end

    assign in_ready     = ~count_reg[1];
    assign push         = in_valid & in_ready;
    assign pop          = q_pop;
    assign q_ctrl.valid = count_reg != 2'd0;
    assign q_ctrl.pop   = pop;
    assign q_data       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push & ~pop)
            count_next = count_reg + 2'd1;
        else if (pop & ~push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    `CC3_ASSERT(a_q_bound, count_reg <= 2'd2)
    `CC3_ASSERT_NEXT(a_q_drain, pop && !push, count_reg == $past(count_reg) - 2'd1)

endmodule

[rtl/core/cc3_back.sv]
// Back end: dot products, Gram determinant, numerators, division, clamping.
// Depends on cc3_pkg, cc3_mul, cc3_div and assert_macros.svh.
`include "assert_macros.svh"

module cc3_back
    import cc3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_ctrl_t   q_ctrl,
    output logic      q_pop,
    input  edge_t     q_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    logic en;
    logic out_valid_reg;

    // Whole pipeline advances unless the output word is held.
    assign en    = ~out_valid_reg | out_ready;
    assign q_pop = q_ctrl.valid & en;

    // Squares and cross terms of the edge vectors.
    logic signed [VW-1:0]   ma_a [9];
    logic signed [VW-1:0]   ma_b [9];
    logic signed [2*VW-1:0] ma_p [9];
    logic                   ma_vld;
    edge_t                  ma_side;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ma_a[k]   = $signed(q_data.v1[k]);
            ma_b[k]   = $signed(q_data.v1[k]);
            ma_a[3+k] = $signed(q_data.v2[k]);
            ma_b[3+k] = $signed(q_data.v2[k]);
            ma_a[6+k] = $signed(q_data.v1[k]);
            ma_b[6+k] = $signed(q_data.v2[k]);
        end
    end

    cc3_mul #(.AW(VW), .BW(VW), .LANES(9), .SW($bits(edge_t))) u_mul_dot (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_ctrl.valid),
        .a(ma_a), .b(ma_b), .side_in(q_data),
        .out_valid(ma_vld), .p(ma_p), .side_out(ma_side)
    );

    // Dot products a, b, c and the differences a-c, b-c.
    logic signed [XW-1:0] dota_next, dotb_next, dotc_next;
    logic signed [XW-1:0] dota_reg, dotb_reg, dotc_reg, amc_reg, bmc_reg;
    edge_t                eb_reg;
    logic                 b_vld_reg;

    always_comb
    begin
        dota_next = XW'(ma_p[0]) + XW'(ma_p[1]) + XW'(ma_p[2]);
        dotb_next = XW'(ma_p[3]) + XW'(ma_p[4]) + XW'(ma_p[5]);
        dotc_next = XW'(ma_p[6]) + XW'(ma_p[7]) + XW'(ma_p[8]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dota_reg <= dota_next;
            dotb_reg <= dotb_next;
            dotc_reg <= dotc_next;
            amc_reg  <= dota_next - dotc_next;
            bmc_reg  <= dotb_next - dotc_next;
            eb_reg   <= ma_side;
        end
    end

    // Gram products a*b, c*c and the weights s, t.
    logic signed [XW-1:0] mc_a [4];
    logic signed [XW-1:0] mc_b [4];
    logic signed [YW-1:0] mc_p [4];
    logic                 mc_vld;
    edge_t                mc_side;

    always_comb
    begin
        mc_a[0] = dota_reg; mc_b[0] = dotb_reg;
        mc_a[1] = dotc_reg; mc_b[1] = dotc_reg;
        mc_a[2] = dotb_reg; mc_b[2] = amc_reg;
        mc_a[3] = dota_reg; mc_b[3] = bmc_reg;
    end

    cc3_mul #(.AW(XW), .BW(XW), .LANES(4), .SW($bits(edge_t))) u_mul_gram (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(b_vld_reg),
        .a(mc_a), .b(mc_b), .side_in(eb_reg),
        .out_valid(mc_vld), .p(mc_p), .side_out(mc_side)
    );

    // Determinant, doubled denominator, numerator terms.
    logic signed [YW-1:0]   det;
    den_side_t              me_side_in, me_side;
    logic signed [YW-1:0]   me_a [6];
    logic signed [VW-1:0]   me_b [6];
    logic signed [ZW-1:0]   me_p [6];
    logic                   me_vld;

    always_comb
    begin
        det              = mc_p[0] - mc_p[1];
        me_side_in.p1    = mc_side.p1;
        me_side_in.den   = {det[DW-2:0], 1'b0};
        me_side_in.degen = mc_p[0] == mc_p[1];
        for (int k = 0; k < 3; k++)
        begin
            me_a[k]   = mc_p[2];
            me_b[k]   = $signed(mc_side.v1[k]);
            me_a[3+k] = mc_p[3];
            me_b[3+k] = $signed(mc_side.v2[k]);
        end
    end

    cc3_mul #(.AW(YW), .BW(VW), .LANES(6), .SW($bits(den_side_t))) u_mul_num (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(mc_vld),
        .a(me_a), .b(me_b), .side_in(me_side_in),
        .out_valid(me_vld), .p(me_p), .side_out(me_side)
    );

    // Numerators, then their doubled magnitudes.
    logic signed [ZW:0] num_reg [3];
    den_side_t          f1_side_reg;
    logic               f1_vld_reg;
    logic [NW-1:0]      nn_reg [3];
    logic [ZW:0]        mag [3];
    logic [DW-1:0]      den_reg;
    div_side_t          f2_side_reg;
    logic               f2_vld_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            mag[k] = num_reg[k][ZW] ? $unsigned(-num_reg[k]) : $unsigned(num_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[k] <= (ZW+1)'(me_p[k]) + (ZW+1)'(me_p[3+k]);
                nn_reg[k]  <= {mag[k], 1'b0};
                f2_side_reg.neg[k] <= num_reg[k][ZW];
            end
            f1_side_reg       <= me_side;
            den_reg           <= f1_side_reg.den;
            f2_side_reg.p1    <= f1_side_reg.p1;
            f2_side_reg.degen <= f1_side_reg.degen;
        end
    end

    // Floor of 2|num| / 2det, one bit per stage.
    logic [QB-1:0] dv_f [3];
    logic [2:0]    dv_ovf;
    logic          dv_vld;
    div_side_t     dv_side;

    cc3_div #(.NW(NW), .DW(DW), .QB(QB), .LANES(3), .SW($bits(div_side_t))) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(f2_vld_reg),
        .n(nn_reg), .d(den_reg), .side_in(f2_side_reg),
        .out_valid(dv_vld), .f(dv_f), .ovf(dv_ovf), .side_out(dv_side)
    );

    // Round, add the first point, clamp.
    out_word_t            out_data_reg, out_data_next;
    logic [QB:0]          fp1 [3];
    logic signed [RW-1:0] res [3];
    logic [COORD_W-1:0]   ctr [3];
    logic [2:0]           sat;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fp1[k] = {1'b0, dv_f[k]} + (QB+1)'(1);
            res[k] = RW'($signed(dv_side.p1[k]))
                   + (dv_side.neg[k] ? -$signed(RW'(fp1[k][QB:1]))
                                     : $signed(RW'(fp1[k][QB:1])));
            sat[k] = 1'b1;
            if (dv_ovf[k])
                ctr[k] = dv_side.neg[k] ? COORD_MIN : COORD_MAX;
            else if (res[k] > RES_MAX)
                ctr[k] = COORD_MAX;
            else if (res[k] < RES_MIN)
                ctr[k] = COORD_MIN;
            else
            begin
                ctr[k] = res[k][COORD_W-1:0];
                sat[k] = 1'b0;
            end
        end
        if (dv_side.degen)
        begin
            out_data_next.center_x = '0;
            out_data_next.center_y = '0;
            out_data_next.center_z = '0;
            out_data_next.status   = STATUS_DEGEN;
        end
        else
        begin
            out_data_next.center_x = ctr[0];
            out_data_next.center_y = ctr[1];
            out_data_next.center_z = ctr[2];
            out_data_next.status   = (|sat) ? STATUS_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg     <= 1'b0;
            f1_vld_reg    <= 1'b0;
            f2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_vld_reg     <= ma_vld;
            f1_vld_reg    <= me_vld;
            f2_vld_reg    <= f1_vld_reg;
            out_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en & dv_vld)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    logic out_zero;
    assign out_zero = out_data_reg.center_x == '0 && out_data_reg.center_y == '0
                   && out_data_reg.center_z == '0;

    `CC3_ASSERT(a_status_code, !out_valid_reg || out_data_reg.status <= STATUS_SAT)
    `CC3_ASSERT(a_degen_zero, !out_valid_reg || out_data_reg.status != STATUS_DEGEN || out_zero)

endmodule

[rtl/core/circumcenter_3d_unit.sv]
// 3-D circumcenter unit: three signed Q16.16 points in, circle center out.
// Depends on cc3_pkg, cc3_front and cc3_back.
//
// Input channel in_valid/in_ready/in_data carries one word per triangle:
// the three points. Output channel out_valid/out_ready/out_data returns one
// word per triangle: center_x/y/z in Q16.16 and a status (ok, degenerate
// for collinear or coincident points with a zero center, or saturated when
// a coordinate was clamped to the Q16.16 range).
// Throughput is one word per cycle while the receiver keeps up. The bulk
// of the pipeline is the 35-stage divider (one quotient bit per stage)
// and the three digit-serial multiplier pipelines of 4, 7 and 7 stages.
// A two-word queue sits between the front end and the back end; when the
// receiver stalls, the back end pipeline holds in place, the queue fills
// and in_ready drops only once it is full.
// Reset clears all valid bits and the queue; nothing is in flight after it.

module circumcenter_3d_unit
    import cc3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    q_ctrl_t q_ctrl;
    logic    q_pop;
    edge_t   q_data;

    // Accept words and form edge vectors.
    cc3_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_ctrl   (q_ctrl),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    // Compute and return the center.
    cc3_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_ctrl    (q_ctrl),
        .q_pop     (q_pop),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
